FILE: src/tdls_pkg.sv
// shared types, codes and constants of the trace-driven link shaper
`timescale 1ns / 1ps
package tdls_pkg;

	localparam int QUEUE_DEPTH_DEF = 256;
	localparam int FRONT_DEPTH     = 4;
	localparam int FRONT_PTR_W     = $clog2(FRONT_DEPTH);
	localparam int RES_DEPTH       = 4;
	localparam int RES_PTR_W       = $clog2(RES_DEPTH);

	localparam logic [10:0] MAX_SERVICE = 11'd1514;
	localparam logic [13:0] MIN_LEN     = 14'd60;

	localparam logic CMD_ARRIVAL     = 1'b0;
	localparam logic CMD_OPPORTUNITY = 1'b1;

	localparam logic [1:0] REG_DELAY   = 2'd0;
	localparam logic [1:0] REG_LOSS    = 2'd1;
	localparam logic [1:0] REG_SERVICE = 2'd2;

	typedef enum logic [2:0] {
		KIND_ACCEPT    = 3'd0,
		KIND_DROP_FULL = 3'd1,
		KIND_DROP_LOSS = 3'd2,
		KIND_DELIVER   = 3'd3,
		KIND_OPP_END   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_END
	} eng_state_t;

	// classified event waiting for the engine
	typedef struct packed {
		logic        cmd;
		logic [31:0] now;
		logic [15:0] tag;
		logic [13:0] len;
		logic        lost;
	} front_item_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [13:0] len;
		logic [31:0] entry;
	} entry_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] tag;
		logic [13:0] len;
		logic [31:0] qdelay;
		logic [10:0] unused;
		logic        last;
	} result_t;

	// engine side of the result queue
	typedef struct packed {
		logic    push;
		result_t data;
	} res_wr_t;

endpackage

FILE: src/trace_driven_link_shaper.sv
// top level of the trace-driven link shaper: config registers, front, engine, result queue
//
// channel   | handshake            | payload
// ----------+----------------------+--------------------------------------------------
// events    | push / full          | cmd, now_ms, packet_tag, packet_len, loss_draw
// results   | pop / empty          | kind, out_tag, out_len, queue_delay_ms,
//           |                      | unused_bytes, last
// config    | cfg_we               | cfg_idx, cfg_wdata
//
// an arrival is handled in the idle state; an opportunity steps through read and evaluate
// per delivered packet, then end; the packet store has a single, registered read port
// events queue up in a 4-entry front queue while the engine works on an opportunity
// results wait in a 4-entry queue; the engine stalls only while that queue is full
// reset is asynchronous and clears all control state; the packet store needs no clearing
`timescale 1ns / 1ps
module trace_driven_link_shaper import tdls_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [31:0] now_ms,
	input  logic [15:0] packet_tag,
	input  logic [13:0] packet_len,
	input  logic [15:0] loss_draw,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [15:0] out_tag,
	output logic [13:0] out_len,
	output logic [31:0] queue_delay_ms,
	output logic [10:0] unused_bytes,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] delay_q;
	logic [15:0] loss_thr_q;
	logic [10:0] service_q;
	logic        item_valid;
	front_item_t item;
	logic        item_pop;
	res_wr_t     res_wr;
	logic        res_full;
	result_t     res_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= '0;
			loss_thr_q <= '0;
			service_q  <= MAX_SERVICE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DELAY:   delay_q    <= cfg_wdata;
				REG_LOSS:    loss_thr_q <= cfg_wdata;
				REG_SERVICE: service_q  <= cfg_wdata[10:0];
				default: begin
				end
			endcase
		end
	end

	tdls_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.cmd            (cmd),
		.now_ms         (now_ms),
		.packet_tag     (packet_tag),
		.packet_len     (packet_len),
		.loss_draw      (loss_draw),
		.loss_threshold (loss_thr_q),
		.item_valid     (item_valid),
		.item           (item),
		.item_pop       (item_pop)
	);

	tdls_engine #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item          (item),
		.item_pop      (item_pop),
		.delay_ms      (delay_q),
		.service_bytes (service_q),
		.res_full      (res_full),
		.res_wr        (res_wr)
	);

	tdls_res_fifo u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.res_wr (res_wr),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.dout   (res_out)
	);

	assign kind           = res_out.kind;
	assign out_tag        = res_out.tag;
	assign out_len        = res_out.len;
	assign queue_delay_ms = res_out.qdelay;
	assign unused_bytes   = res_out.unused;
	assign last           = res_out.last;

	// an event retires exactly when its final result is written
	a_pop_with_last: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> (res_wr.push && res_wr.data.last))
		else $error("event retired without its final result");

	a_last_retires: assert property (@(posedge clk) disable iff (!arst_n)
		(res_wr.push && res_wr.data.last) |-> item_pop)
		else $error("final result written while the event stays queued");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_wr.push |-> !res_full)
		else $error("result written into a full result queue");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> item_valid)
		else $error("engine took an event from an empty front queue");

	a_deliver_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_wr.push && (res_wr.data.kind == KIND_DELIVER)) |->
		(!res_wr.data.last && (res_wr.data.unused == '0)))
		else $error("delivery result with final flag or unused bytes");

endmodule

FILE: src/tdls_front.sv
// front end: accepts events, clamps length, makes the loss decision, queues them
`timescale 1ns / 1ps
module tdls_front import tdls_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [31:0] now_ms,
	input  logic [15:0] packet_tag,
	input  logic [13:0] packet_len,
	input  logic [15:0] loss_draw,
	input  logic [15:0] loss_threshold,
	output logic        item_valid,
	output front_item_t item,
	input  logic        item_pop
);

	front_item_t            q_mem [FRONT_DEPTH];
	logic [FRONT_PTR_W-1:0] wr_ptr_q;
	logic [FRONT_PTR_W-1:0] rd_ptr_q;
	logic [FRONT_PTR_W:0]   cnt_q;
	logic                   accept;
	front_item_t            new_item;

	assign full       = (cnt_q == (FRONT_PTR_W+1)'(FRONT_DEPTH));
	assign accept     = push && !full;
	assign item_valid = (cnt_q != '0);
	assign item       = q_mem[rd_ptr_q];

	always_comb begin
		new_item.cmd  = cmd;
		new_item.now  = now_ms;
		new_item.tag  = packet_tag;
		new_item.len  = (packet_len < MIN_LEN) ? MIN_LEN : packet_len;
		new_item.lost = (loss_draw < loss_threshold);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (item_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (accept && !item_pop) cnt_q <= cnt_q + 1'b1;
			else if (!accept && item_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) q_mem[wr_ptr_q] <= new_item;
	end

endmodule

FILE: src/tdls_engine.sv
// back end: packet store, pointers and the opportunity sequencer
`timescale 1ns / 1ps
module tdls_engine import tdls_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  front_item_t item,
	output logic        item_pop,
	input  logic [15:0] delay_ms,
	input  logic [10:0] service_bytes,
	input  logic        res_full,
	output res_wr_t     res_wr
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t     mem [QUEUE_DEPTH];
	entry_t     rd_q;
	eng_state_t state_q, state_d;
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic [13:0] earned_q;
	logic        partial_q;
	logic        first_q;
	logic [10:0] bytes_q;
	logic [31:0] now_q;

	logic        store_full;
	logic        opp_start;
	logic        resume;
	logic        wr_en;
	entry_t      wr_entry;
	logic [10:0] grant;
	logic [32:0] rel_sum;
	logic        released;
	logic [14:0] fin_sum;
	logic        fin_ok;
	logic        fits;
	logic        step_deliver, step_absorb, step_split, step_hold;

	function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] i);
		next_idx = (i == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign store_full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign grant      = (service_bytes > MAX_SERVICE) ? MAX_SERVICE : service_bytes;
	assign opp_start  = (state_q == ST_IDLE) && item_valid && (item.cmd == CMD_OPPORTUNITY);
	assign resume     = partial_q && (count_q != '0);

	// release time is compared without wrap
	assign rel_sum  = {1'b0, rd_q.entry} + {17'b0, delay_ms};
	assign released = (rel_sum <= {1'b0, now_q});
	assign fin_sum  = {1'b0, earned_q} + {4'b0, bytes_q};
	assign fin_ok   = (fin_sum >= {1'b0, rd_q.len});
	assign fits     = ({3'b0, bytes_q} >= rd_q.len);

	assign wr_entry.tag   = item.tag;
	assign wr_entry.len   = item.len;
	assign wr_entry.entry = item.now;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (opp_start) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ((count_q == '0) || (bytes_q == '0)) ? ST_END : ST_EVAL;
			end
			ST_EVAL: begin
				if (step_deliver) state_d = ST_READ;
				else if (step_absorb || step_split || step_hold) state_d = ST_END;
			end
			ST_END: begin
				if (item_pop) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_pop     = 1'b0;
		res_wr       = '0;
		wr_en        = 1'b0;
		step_deliver = 1'b0;
		step_absorb  = 1'b0;
		step_split   = 1'b0;
		step_hold    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && (item.cmd == CMD_ARRIVAL) && !res_full) begin
					item_pop         = 1'b1;
					res_wr.push      = 1'b1;
					res_wr.data.tag  = item.tag;
					res_wr.data.len  = item.len;
					res_wr.data.last = 1'b1;
					// loss test wins over a full store
					if (item.lost) begin
						res_wr.data.kind = KIND_DROP_LOSS;
					end else if (store_full) begin
						res_wr.data.kind = KIND_DROP_FULL;
					end else begin
						res_wr.data.kind = KIND_ACCEPT;
						wr_en            = 1'b1;
					end
				end
			end
			ST_READ: begin
			end
			ST_EVAL: begin
				if (!res_full) begin
					if (first_q) begin
						if (fin_ok) step_deliver = 1'b1;
						else step_absorb = 1'b1;
					end else if (!released) begin
						step_hold = 1'b1;
					end else if (fits) begin
						step_deliver = 1'b1;
					end else begin
						step_split = 1'b1;
					end
				end
				if (step_deliver) begin
					res_wr.push        = 1'b1;
					res_wr.data.kind   = KIND_DELIVER;
					res_wr.data.tag    = rd_q.tag;
					res_wr.data.len    = rd_q.len;
					res_wr.data.qdelay = now_q - rd_q.entry;
				end
			end
			ST_END: begin
				if (!res_full) begin
					item_pop           = 1'b1;
					res_wr.push        = 1'b1;
					res_wr.data.kind   = KIND_OPP_END;
					res_wr.data.unused = bytes_q;
					res_wr.data.last   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			earned_q  <= '0;
			partial_q <= 1'b0;
			first_q   <= 1'b0;
			bytes_q   <= '0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				tail_q  <= next_idx(tail_q);
				count_q <= count_q + 1'b1;
			end
			if (opp_start) begin
				bytes_q <= grant;
				first_q <= resume;
				if (!resume) begin
					partial_q <= 1'b0;
					earned_q  <= '0;
				end
			end
			if (step_deliver) begin
				head_q    <= next_idx(head_q);
				count_q   <= count_q - 1'b1;
				partial_q <= 1'b0;
				earned_q  <= '0;
				first_q   <= 1'b0;
				// a resumed head only needs what it has not yet earned
				if (first_q) bytes_q <= bytes_q - 11'(rd_q.len - earned_q);
				else bytes_q <= bytes_q - 11'(rd_q.len);
			end
			if (step_absorb) begin
				earned_q <= 14'(fin_sum);
				bytes_q  <= '0;
			end
			if (step_split) begin
				partial_q <= 1'b1;
				earned_q  <= {3'b0, bytes_q};
				bytes_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (opp_start) now_q <= item.now;
		if (wr_en) mem[tail_q] <= wr_entry;
		if (state_q == ST_READ) rd_q <= mem[head_q];
	end

endmodule

FILE: src/tdls_res_fifo.sv
// result queue between the engine and the output side
`timescale 1ns / 1ps
module tdls_res_fifo import tdls_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  res_wr_t res_wr,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output result_t dout
);

	result_t              q_mem [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_PTR_W:0]   cnt_q;
	logic                 do_pop;

	assign full   = (cnt_q == (RES_PTR_W+1)'(RES_DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign dout   = q_mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_wr.push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (res_wr.push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!res_wr.push && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_wr.push) q_mem[wr_ptr_q] <= res_wr.data;
	end

endmodule

FILE: sim/tb_trace_driven_link_shaper.sv
// trace-driven link shaper testbench: directed and random events checked by a predictor
`timescale 1ns / 1ps
module tb_trace_driven_link_shaper;
	import tdls_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	localparam int LIMIT = 1_500_000;
	localparam logic [1:0] REG_SPARE = 2'd3;

	class shaper_scoreboard;
		entry_t      store [DEPTH];
		int unsigned head_idx = 0;
		int unsigned tail_idx = 0;
		int unsigned stored_pkts = 0;
		int unsigned earned = 0;
		bit          partial = 0;
		logic [15:0] delay_ms = '0;
		logic [15:0] loss_thr = '0;
		logic [10:0] grant = MAX_SERVICE;
		result_t     due_results [$];
		int          errors = 0;
		int          n_events = 0;
		int          n_checked = 0;
		int          n_opps = 0;
		int          max_burst = 0;
		int          kind_cnt [5] = '{default: 0};

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_DELAY:   delay_ms = val;
				REG_LOSS:    loss_thr = val;
				REG_SERVICE: grant = val[10:0];
				default: ;
			endcase
		endfunction

		function void add(kind_t k, logic [15:0] tg, logic [13:0] ln, logic [31:0] qd,
			logic [10:0] un, logic lst);
			result_t r;
			r.kind   = k;
			r.tag    = tg;
			r.len    = ln;
			r.qdelay = qd;
			r.unused = un;
			r.last   = lst;
			due_results.insert(due_results.size(), r);
		endfunction

		function void drop_head();
			head_idx = (head_idx + 1) % DEPTH;
			stored_pkts--;
			partial = 0;
			earned = 0;
		endfunction

		function void deliver_head(logic [31:0] t);
			add(KIND_DELIVER, store[head_idx].tag, store[head_idx].len,
				t - store[head_idx].entry, '0, 1'b0);
		endfunction

		function void predict_event(logic c, logic [31:0] t, logic [15:0] tg, logic [13:0] ln,
			logic [15:0] dr);
			int unsigned bytes;
			int          n_before;
			logic [13:0] eff;
			n_before = due_results.size();
			n_events++;
			if (c == CMD_ARRIVAL) begin
				eff = (ln < MIN_LEN) ? MIN_LEN : ln;
				// the loss draw is tested before the store limit
				if (dr < loss_thr) begin
					add(KIND_DROP_LOSS, tg, eff, '0, '0, 1'b1);
				end else if (stored_pkts >= DEPTH) begin
					add(KIND_DROP_FULL, tg, eff, '0, '0, 1'b1);
				end else begin
					store[tail_idx] = '{tag: tg, len: eff, entry: t};
					tail_idx = (tail_idx + 1) % DEPTH;
					stored_pkts++;
					add(KIND_ACCEPT, tg, eff, '0, '0, 1'b1);
				end
			end else begin
				n_opps++;
				bytes = 32'((grant > MAX_SERVICE) ? MAX_SERVICE : grant);
				// a partly served head is served further without a release check
				if (partial && stored_pkts > 0) begin
					if (earned + bytes >= store[head_idx].len) begin
						deliver_head(t);
						bytes -= store[head_idx].len - earned;
						drop_head();
					end else begin
						earned += bytes;
						bytes = 0;
					end
				end else begin
					partial = 0;
					earned = 0;
				end
				while (bytes > 0 && stored_pkts > 0 &&
					{1'b0, store[head_idx].entry} + {17'b0, delay_ms} <= {1'b0, t}) begin
					if (bytes >= store[head_idx].len) begin
						deliver_head(t);
						bytes -= store[head_idx].len;
						drop_head();
					end else begin
						partial = 1;
						earned = bytes;
						bytes = 0;
					end
				end
				add(KIND_OPP_END, '0, '0, '0, bytes[10:0], 1'b1);
			end
			if (due_results.size() - n_before > max_burst)
				max_burst = due_results.size() - n_before;
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task cmp(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report_mismatch($sformatf("result %0d field %s: got %0h, expected %0h",
					n_checked, name, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result %0d (kind %0d tag %0h) with nothing due",
					n_checked, got.kind, got.tag));
				n_checked++;
				return;
			end
			want = due_results.pop_front();
			cmp("kind", 32'(got.kind), 32'(want.kind));
			cmp("out_tag", 32'(got.tag), 32'(want.tag));
			cmp("out_len", 32'(got.len), 32'(want.len));
			cmp("queue_delay_ms", got.qdelay, want.qdelay);
			cmp("unused_bytes", 32'(got.unused), 32'(want.unused));
			cmp("last", 32'(got.last), 32'(want.last));
			kind_cnt[int'(want.kind)]++;
			n_checked++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        cmd;
	logic [31:0] now_ms;
	logic [15:0] packet_tag;
	logic [13:0] packet_len;
	logic [15:0] loss_draw;
	logic        empty;
	logic        pop;
	logic [2:0]  kind;
	logic [15:0] out_tag;
	logic [13:0] out_len;
	logic [31:0] queue_delay_ms;
	logic [10:0] unused_bytes;
	logic        last;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_wdata;

	shaper_scoreboard sb = new;
	bit          idle_on = 1;
	logic [31:0] t_ms;
	int          cycle_cnt = 0;

	trace_driven_link_shaper dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.now_ms(now_ms),
		.packet_tag(packet_tag),
		.packet_len(packet_len),
		.loss_draw(loss_draw),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.out_tag(out_tag),
		.out_len(out_len),
		.queue_delay_ms(queue_delay_ms),
		.unused_bytes(unused_bytes),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d results still due", cycle_cnt,
			sb.due_results.size());
		$display("Some tests failed");
		$finish;
	end

	// push stays high after a transfer so back-to-back events need no second assignment
	task automatic send_event(logic c, logic [31:0] t, logic [15:0] tg, logic [13:0] ln,
		logic [15:0] dr);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		push       <= 1'b1;
		cmd        <= c;
		now_ms     <= t;
		packet_tag <= tg;
		packet_len <= ln;
		loss_draw  <= dr;
		do @(posedge clk); while (full);
		sb.predict_event(c, t, tg, ln, dr);
	endtask

	task automatic send_arrival(logic [31:0] t, logic [15:0] tg, logic [13:0] ln,
		logic [15:0] dr);
		send_event(CMD_ARRIVAL, t, tg, ln, dr);
	endtask

	// unused payload of an opportunity still gets random values
	task automatic send_opp(logic [31:0] t);
		send_event(CMD_OPPORTUNITY, t, 16'($urandom), 14'($urandom), 16'($urandom));
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		push <= 1'b0;
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic run_traffic(int n_items, int unsigned max_step);
		logic [13:0] ln;
		int          sel;
		repeat (n_items) begin
			t_ms += $urandom_range(0, max_step);
			if ($urandom_range(0, 99) < 55) begin
				sel = $urandom_range(0, 9);
				if (sel == 0)
					ln = 14'($urandom_range(0, 59));
				else if (sel == 1)
					ln = 14'($urandom);
				else
					ln = 14'($urandom_range(60, 1600));
				send_arrival(t_ms, 16'($urandom), ln, 16'($urandom));
			end else begin
				send_opp(t_ms);
			end
		end
	endtask

	initial begin
		pop <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				pop <= 1'b1;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n === 1'b1 && pop && !empty) begin
			got.kind   = kind_t'(kind);
			got.tag    = out_tag;
			got.len    = out_len;
			got.qdelay = queue_delay_ms;
			got.unused = unused_bytes;
			got.last   = last;
			sb.check_result(got);
		end
	end

	initial begin
		arst_n     <= 1'b0;
		push       <= 1'b0;
		cmd        <= CMD_ARRIVAL;
		now_ms     <= '0;
		packet_tag <= '0;
		packet_len <= '0;
		loss_draw  <= '0;
		cfg_we     <= 1'b0;
		cfg_idx    <= REG_DELAY;
		cfg_wdata  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no delay, no loss, full grant
		send_arrival(32'd0, 16'h0000, 14'd0, 16'h0000);
		send_arrival(32'd5, 16'hFFFF, 14'd60, 16'hFFFF);
		send_arrival(32'd5, 16'h1234, 14'd3000, 16'h5A5A);
		send_opp(32'd10);
		send_opp(32'd10);
		send_opp(32'd20);
		send_opp(32'd20);

		// oversized grant saturates, half the draws are lost
		write_reg(REG_DELAY, 16'd100);
		write_reg(REG_LOSS, 16'h8000);
		write_reg(REG_SERVICE, 16'hFFFF);
		send_arrival(32'd1000, 16'h0001, 14'h3FFF, 16'h7FFF);
		send_arrival(32'd1000, 16'h0002, 14'd3100, 16'h8000);
		send_opp(32'd1099);
		send_opp(32'd1100);
		// time goes backwards while the head is partly served
		send_opp(32'd50);

		write_reg(REG_DELAY, 16'd0);
		write_reg(REG_LOSS, 16'd0);
		write_reg(REG_SERVICE, 16'd0);
		send_opp(32'd60);
		write_reg(REG_SERVICE, 16'd59);
		send_opp(32'd70);
		write_reg(REG_SERVICE, 16'(MAX_SERVICE));
		// finishing the head now gives a wrapped queue delay
		send_opp(32'd80);
		send_arrival(32'hFFFF_FFFF, 16'hA5A5, 14'd1514, 16'h0000);
		send_opp(32'hFFFF_FFFF);
		send_arrival(32'hFFFF_FFFF, 16'h5A5A, 14'd61, 16'hFFFF);
		send_opp(32'hFFFF_FFFF);

		// random traffic, store is empty so time may restart anywhere
		t_ms = $urandom_range(0, 32'h3FFF_FFFF);
		write_reg(REG_DELAY, 16'($urandom_range(0, 50)));
		write_reg(REG_LOSS, 16'h1000);
		run_traffic(40, 20);

		write_reg(REG_DELAY, 16'hFFFF);
		write_reg(REG_LOSS, 16'd0);
		write_reg(REG_SERVICE, 16'($urandom_range(60, 1514)));
		run_traffic(30, 4000);

		// fill the store, then overflow it
		while (sb.stored_pkts < DEPTH) begin
			t_ms += $urandom_range(0, 3);
			send_arrival(t_ms, 16'($urandom), 14'($urandom_range(0, 120)), 16'($urandom));
		end
		repeat (6)
			send_arrival(t_ms, 16'($urandom), 14'($urandom_range(0, 120)), 16'($urandom));
		write_reg(REG_LOSS, 16'h4000);
		send_arrival(t_ms, 16'($urandom), 14'($urandom_range(60, 120)),
			16'($urandom_range(0, 16'h3FFF)));
		repeat (10)
			send_arrival(t_ms, 16'($urandom), 14'($urandom_range(0, 120)), 16'($urandom));

		// drain with saturated grants, short packets give the longest bursts
		write_reg(REG_DELAY, 16'd0);
		write_reg(REG_SERVICE, 16'hFFFF);
		while (sb.stored_pkts > 0) begin
			t_ms += 1;
			send_opp(t_ms);
		end

		write_reg(REG_LOSS, 16'hFFFF);
		write_reg(REG_SERVICE, 16'd60);
		write_reg(REG_SPARE, 16'($urandom));
		run_traffic(15, 10);

		idle_on = 0;
		write_reg(REG_DELAY, 16'($urandom_range(0, 30)));
		write_reg(REG_LOSS, 16'($urandom_range(0, 16'h2000)));
		write_reg(REG_SERVICE, 16'($urandom));
		run_traffic(40, 15);

		push <= 1'b0;
		while (sb.due_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d events, %0d results: %0d accepted, %0d full drops, %0d loss drops",
			sb.n_events, sb.n_checked, sb.kind_cnt[KIND_ACCEPT], sb.kind_cnt[KIND_DROP_FULL],
			sb.kind_cnt[KIND_DROP_LOSS]);
		$display("%0d deliveries over %0d opportunities, up to %0d results per event, %0d errors",
			sb.kind_cnt[KIND_DELIVER], sb.n_opps, sb.max_burst, sb.errors);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
src/tdls_pkg.sv
src/tdls_front.sv
src/tdls_engine.sv
src/tdls_res_fifo.sv
src/trace_driven_link_shaper.sv
sim/tb_trace_driven_link_shaper.sv
